@@ sv/lgsc_pkg.sv @@
`timescale 1ns / 1ps

package lgsc_pkg;

  localparam int NUM_SLOTS    = 8;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);
  localparam int ROW_CELLS    = 16;
  localparam int NUM_ROWS     = 2;
  localparam int SHADOW_CELLS = 32;
  localparam int CELL_W       = $clog2(SHADOW_CELLS);
  localparam int IDX_W        = 7;
  localparam logic [4:0] COL_MAX     = 5'd31;
  localparam logic [7:0] XLAT_BASE   = 8'hC0;
  localparam logic [7:0] GLYPH_LIMIT = 8'hA0;

  localparam logic [7:0] XLAT [64] = '{
    8'h41, 8'hA0, 8'h42, 8'hA1, 8'hE0, 8'h45, 8'hA3, 8'hA4,
    8'hA5, 8'h03, 8'h4B, 8'hA7, 8'h4D, 8'h48, 8'h4F, 8'hA8,
    8'h50, 8'h43, 8'h54, 8'hA9, 8'hAA, 8'h58, 8'hE1, 8'hAB,
    8'hAC, 8'hE2, 8'hAD, 8'hAE, 8'h62, 8'hAF, 8'hB0, 8'hB1,
    8'h61, 8'hB2, 8'hB3, 8'hB4, 8'hE3, 8'h65, 8'hB6, 8'hB7,
    8'hB8, 8'hB9, 8'hBA, 8'hBB, 8'hBC, 8'hBD, 8'h6F, 8'hBE,
    8'h70, 8'h63, 8'hBF, 8'h79, 8'hE4, 8'h78, 8'hE5, 8'hC0,
    8'hC1, 8'hE6, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7
  };

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_SLOT,
    ST_CELL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic classify;
    logic slot_next;
    logic cell_next;
    logic pick;
    logic pick_last;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic is_put;
    logic need_glyph;
    logic hit;
    logic slot_empty;
    logic cell_match;
    logic cell_last;
    logic slot_last;
    logic out_busy;
  } dp_sts_t;

endpackage

@@ sv/lcd_glyph_slot_cache.sv @@
`timescale 1ns / 1ps
// Channel | Handshake            | Word
// in      | in_valid_i/in_stall_o | op_i, char_code_i, col_i, row_i
// out     | out_valid_o/out_stall_i | shows_char_o, display_code_o, load_glyph_o,
//         |                      | glyph_slot_o, glyph_char_o, cursor_col_o, cursor_row_o
// One word at a time: move, clear, direct codes and slot hits pass IDLE, CLASSIFY, DONE.
// A slot miss scans slots in order, one shadow cell per cycle for an occupied slot;
// it takes the first slot that is empty or shown in no cell, else the last one loaded.
// Reset empties all slots and the shadow and homes the cursor; no clearing pass.
// The result sits in an output register; a new word is taken while it waits.

module lcd_glyph_slot_cache (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic [7:0] char_code_i,
  input  logic [3:0] col_i,
  input  logic [1:0] row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       shows_char_o,
  output logic [7:0] display_code_o,
  output logic       load_glyph_o,
  output logic [2:0] glyph_slot_o,
  output logic [7:0] glyph_char_o,
  output logic [4:0] cursor_col_o,
  output logic       cursor_row_o
);

  lgsc_pkg::dp_cmd_t cmd;
  lgsc_pkg::dp_sts_t sts;

  lgsc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lgsc_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .char_code_i    (char_code_i),
    .col_i          (col_i),
    .row_i          (row_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .shows_char_o   (shows_char_o),
    .display_code_o (display_code_o),
    .load_glyph_o   (load_glyph_o),
    .glyph_slot_o   (glyph_slot_o),
    .glyph_char_o   (glyph_char_o),
    .cursor_col_o   (cursor_col_o),
    .cursor_row_o   (cursor_row_o)
  );

endmodule

@@ sv/lgsc_dp.sv @@
`timescale 1ns / 1ps

module lgsc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lgsc_pkg::dp_cmd_t   cmd_i,
  output lgsc_pkg::dp_sts_t   sts_o,
  input  logic [1:0]          op_i,
  input  logic [7:0]          char_code_i,
  input  logic [3:0]          col_i,
  input  logic [1:0]          row_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                shows_char_o,
  output logic [7:0]          display_code_o,
  output logic                load_glyph_o,
  output logic [2:0]          glyph_slot_o,
  output logic [7:0]          glyph_char_o,
  output logic [4:0]          cursor_col_o,
  output logic                cursor_row_o
);

  lgsc_pkg::op_e op_q;
  logic [7:0] code_q;
  logic [3:0] col_q;
  logic [1:0] row_q;

  logic [7:0] slot_q [lgsc_pkg::NUM_SLOTS];
  logic [7:0] cell_q [lgsc_pkg::SHADOW_CELLS];
  logic [lgsc_pkg::SLOT_W-1:0] last_slot_q;
  logic [lgsc_pkg::SLOT_W-1:0] j_q;
  logic [lgsc_pkg::CELL_W-1:0] n_q;
  logic [4:0] cur_x_q, cur_x_d;
  logic       cur_y_q, cur_y_d;

  logic [7:0] res_dcode_q;
  logic       res_load_q;
  logic [lgsc_pkg::SLOT_W-1:0] res_slot_q;

  logic       out_valid_q;
  logic       out_shows_q;
  logic [7:0] out_dcode_q;
  logic       out_load_q;
  logic [2:0] out_slot_q;
  logic [7:0] out_char_q;
  logic [4:0] out_col_q;
  logic       out_row_q;

  logic [7:0] xlat_val;
  logic       below_base;
  logic       hit;
  logic [lgsc_pkg::SLOT_W-1:0] hit_idx;
  logic [lgsc_pkg::SLOT_W-1:0] pick_idx;
  logic [lgsc_pkg::IDX_W-1:0]  cell_idx;
  logic       is_put;

  assign is_put     = (op_q == lgsc_pkg::OP_PUT);
  assign below_base = (code_q < lgsc_pkg::XLAT_BASE);
  assign xlat_val   = lgsc_pkg::XLAT[code_q[5:0]];

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = lgsc_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_q[i] == code_q) begin
        hit     = 1'b1;
        hit_idx = lgsc_pkg::SLOT_W'(i);
      end
    end
  end

  assign pick_idx = cmd_i.pick ? j_q : last_slot_q;
  assign cell_idx = (cur_y_q ? lgsc_pkg::IDX_W'(lgsc_pkg::ROW_CELLS) : '0)
                  + lgsc_pkg::IDX_W'(cur_x_q);

  always_comb begin
    sts_o.is_put     = is_put;
    sts_o.need_glyph = !below_base && (xlat_val >= lgsc_pkg::GLYPH_LIMIT);
    sts_o.hit        = hit;
    sts_o.slot_empty = (slot_q[j_q] == 8'd0);
    sts_o.cell_match = (cell_q[n_q] == slot_q[j_q]);
    sts_o.cell_last  = (n_q == lgsc_pkg::CELL_W'(lgsc_pkg::SHADOW_CELLS - 1));
    sts_o.slot_last  = (j_q == lgsc_pkg::SLOT_W'(lgsc_pkg::NUM_SLOTS - 1));
    sts_o.out_busy   = out_valid_q && out_stall_i;
  end

  always_comb begin
    cur_x_d = cur_x_q;
    cur_y_d = cur_y_q;
    unique case (op_q)
      lgsc_pkg::OP_PUT: begin
        if (cur_x_q < lgsc_pkg::COL_MAX) begin
          cur_x_d = cur_x_q + 5'd1;
        end
      end
      lgsc_pkg::OP_MOVE: begin
        if ({1'b0, row_q} < 3'(lgsc_pkg::NUM_ROWS)) begin
          cur_x_d = {1'b0, col_q};
          cur_y_d = row_q[0];
        end
      end
      lgsc_pkg::OP_CLEAR: begin
        cur_x_d = '0;
        cur_y_d = 1'b0;
      end
      lgsc_pkg::OP_NOP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= lgsc_pkg::op_e'(op_i);
      code_q <= char_code_i;
      col_q  <= col_i;
      row_q  <= row_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lgsc_pkg::NUM_SLOTS; i++) begin
        slot_q[i] <= '0;
      end
      for (int i = 0; i < lgsc_pkg::SHADOW_CELLS; i++) begin
        cell_q[i] <= '0;
      end
      last_slot_q <= '0;
      j_q         <= '0;
      n_q         <= '0;
      cur_x_q     <= '0;
      cur_y_q     <= 1'b0;
      res_dcode_q <= '0;
      res_load_q  <= 1'b0;
      res_slot_q  <= '0;
      out_valid_q <= 1'b0;
      out_shows_q <= 1'b0;
      out_dcode_q <= '0;
      out_load_q  <= 1'b0;
      out_slot_q  <= '0;
      out_char_q  <= '0;
      out_col_q   <= '0;
      out_row_q   <= 1'b0;
    end else begin
      if (cmd_i.classify) begin
        j_q        <= '0;
        n_q        <= '0;
        res_load_q <= 1'b0;
        res_slot_q <= '0;
        if (below_base) begin
          res_dcode_q <= code_q;
        end else if (xlat_val < lgsc_pkg::GLYPH_LIMIT) begin
          res_dcode_q <= xlat_val;
        end else begin
          res_dcode_q <= 8'(hit_idx);
        end
      end
      if (cmd_i.slot_next) begin
        j_q <= j_q + lgsc_pkg::SLOT_W'(1);
        n_q <= '0;
      end
      if (cmd_i.cell_next) begin
        n_q <= n_q + lgsc_pkg::CELL_W'(1);
      end
      if (cmd_i.pick || cmd_i.pick_last) begin
        slot_q[pick_idx] <= code_q;
        last_slot_q      <= pick_idx;
        res_dcode_q      <= 8'(pick_idx);
        res_load_q       <= 1'b1;
        res_slot_q       <= pick_idx;
      end
      if (cmd_i.finish) begin
        cur_x_q <= cur_x_d;
        cur_y_q <= cur_y_d;
        if (op_q == lgsc_pkg::OP_CLEAR) begin
          for (int i = 0; i < lgsc_pkg::SHADOW_CELLS; i++) begin
            cell_q[i] <= '0;
          end
        end else if (is_put &&
                     cell_idx < lgsc_pkg::IDX_W'(lgsc_pkg::SHADOW_CELLS)) begin
          cell_q[cell_idx[lgsc_pkg::CELL_W-1:0]] <= code_q;
        end
        out_valid_q <= 1'b1;
        out_shows_q <= is_put;
        out_dcode_q <= is_put ? res_dcode_q : 8'd0;
        out_load_q  <= is_put && res_load_q;
        out_slot_q  <= (is_put && res_load_q) ? 3'(res_slot_q) : 3'd0;
        out_char_q  <= (is_put && res_load_q) ? code_q : 8'd0;
        out_col_q   <= cur_x_d;
        out_row_q   <= cur_y_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign shows_char_o   = out_shows_q;
  assign display_code_o = out_dcode_q;
  assign load_glyph_o   = out_load_q;
  assign glyph_slot_o   = out_slot_q;
  assign glyph_char_o   = out_char_q;
  assign cursor_col_o   = out_col_q;
  assign cursor_row_o   = out_row_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |-> !(out_valid_q && out_stall_i))
    else $error("result word overwritten while stalled");

  a_pick_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.pick || cmd_i.pick_last) |-> (is_put && sts_o.need_glyph && !hit))
    else $error("slot picked without a glyph miss");

  a_cell_no_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.cell_next |-> !sts_o.cell_last)
    else $error("shadow scan wrapped");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_load_q) |-> (out_shows_q && out_dcode_q == 8'(out_slot_q)))
    else $error("load request without matching display code");

endmodule

@@ sv/lgsc_ctrl.sv @@
`timescale 1ns / 1ps

module lgsc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lgsc_pkg::dp_sts_t   sts_i,
  output lgsc_pkg::dp_cmd_t   cmd_o
);

  lgsc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lgsc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != lgsc_pkg::ST_IDLE);
    unique case (state_q)
      lgsc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = lgsc_pkg::ST_CLASSIFY;
        end
      end
      lgsc_pkg::ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        if (sts_i.is_put && sts_i.need_glyph && !sts_i.hit) begin
          state_d = lgsc_pkg::ST_SLOT;
        end else begin
          state_d = lgsc_pkg::ST_DONE;
        end
      end
      lgsc_pkg::ST_SLOT: begin
        if (sts_i.slot_empty) begin
          cmd_o.pick = 1'b1;
          state_d    = lgsc_pkg::ST_DONE;
        end else begin
          state_d = lgsc_pkg::ST_CELL;
        end
      end
      lgsc_pkg::ST_CELL: begin
        priority if (sts_i.cell_match) begin
          if (sts_i.slot_last) begin
            cmd_o.pick_last = 1'b1;
            state_d         = lgsc_pkg::ST_DONE;
          end else begin
            cmd_o.slot_next = 1'b1;
            state_d         = lgsc_pkg::ST_SLOT;
          end
        end else if (sts_i.cell_last) begin
          cmd_o.pick = 1'b1;
          state_d    = lgsc_pkg::ST_DONE;
        end else begin
          cmd_o.cell_next = 1'b1;
        end
      end
      lgsc_pkg::ST_DONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = lgsc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lgsc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
